// ----- src/lac_pkg.sv -----
// ----------------------------------------------------------------------------
// lac_pkg
// shared constants, types and command struct for the lru associative cache
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int SLOTS     = 16;
    localparam int DATA_BITS = 64;

    localparam int KEY_W   = 32;
    localparam int AGE_W   = 32;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // oldest-slot search: first level reduces groups of GRP_SIZE slots
    localparam int GRP_SIZE = 4;
    localparam int NGRP     = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic OP_FIND = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_UPD,
        ST_RESP
    } lac_state_t;

    typedef struct packed {
        logic accept;    // latch request, advance counter on add
        logic look;      // key compare and first level of age search
        logic sel;       // priority encode and final victim choice
        logic upd;       // write stamps/key/data, read hit data
        logic load_out;  // load result register
    } lac_cmd_t;

endpackage

// ----- src/lac_ctrl.sv -----
// ----------------------------------------------------------------------------
// lac_ctrl
// request sequencer and result valid flag for the lru associative cache
// ----------------------------------------------------------------------------
module lac_ctrl
    import lac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output lac_cmd_t cmd
);

    lac_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                cmd.sel    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // next request may enter as this result moves out
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    s_ready      = 1'b1;
                    state_next   = s_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.accept = s_ready && s_valid;
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- src/lac_dpath.sv -----
// ----------------------------------------------------------------------------
// lac_dpath
// slot tags, age stamps, data memory, oldest search and result register
// ----------------------------------------------------------------------------
module lac_dpath
    import lac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  lac_cmd_t            cmd,
    input  logic                s_operation,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [ENTRY_W-1:0]  s_entry_in,
    input  logic                s_refresh,
    output logic                m_hit,
    output logic [ENTRY_W-1:0]  m_entry_out
);

    // latched request
    logic                 req_op_reg;
    logic [KEY_W-1:0]     req_key_reg;
    logic [DATA_BITS-1:0] req_data_reg;
    logic                 req_refresh_reg;

    logic [AGE_W-1:0]     use_count_reg;

    logic [KEY_W-1:0]     slot_key_reg [SLOTS];
    logic [AGE_W-1:0]     slot_age_reg [SLOTS];
    logic [DATA_BITS-1:0] slot_data_mem [SLOTS];

    logic [SLOTS-1:0]     match_reg, match_next;
    logic [AGE_W-1:0]     grp_age_reg [NGRP];
    logic [AGE_W-1:0]     grp_age_next [NGRP];
    logic [IDX_W-1:0]     grp_idx_reg [NGRP];
    logic [IDX_W-1:0]     grp_idx_next [NGRP];

    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     victim_idx_reg, victim_idx_next;
    logic [AGE_W-1:0]     victim_age;

    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 m_hit_reg;
    logic [ENTRY_W-1:0]   m_entry_out_reg;

    // key compare, empty slots never match
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_next[i] = (slot_age_reg[i] != '0) && (slot_key_reg[i] == req_key_reg);
        end
    end

    // first level of oldest search: empty slots have age zero so they win,
    // strict compare keeps the lowest index on ties
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_age_next[g] = slot_age_reg[g * GRP_SIZE];
            grp_idx_next[g] = IDX_W'(g * GRP_SIZE);
            for (int j = 1; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < SLOTS) begin
                    if (slot_age_reg[g * GRP_SIZE + j] < grp_age_next[g]) begin
                        grp_age_next[g] = slot_age_reg[g * GRP_SIZE + j];
                        grp_idx_next[g] = IDX_W'(g * GRP_SIZE + j);
                    end
                end
            end
        end
    end

    // lowest matching index, and second level of oldest search
    always_comb begin
        hit_next     = |match_reg;
        hit_idx_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                hit_idx_next = IDX_W'(i);
            end
        end
        victim_age      = grp_age_reg[0];
        victim_idx_next = grp_idx_reg[0];
        for (int g = 1; g < NGRP; g++) begin
            if (grp_age_reg[g] < victim_age) begin
                victim_age      = grp_age_reg[g];
                victim_idx_next = grp_idx_reg[g];
            end
        end
    end

    // control-side state: counter, tags and stamps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_count_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_key_reg[i] <= '0;
                slot_age_reg[i] <= '0;
            end
        end else begin
            if (cmd.accept && s_operation == OP_ADD) begin
                use_count_reg <= use_count_reg + 1'b1;
            end
            if (cmd.upd) begin
                if (hit_reg) begin
                    if (req_op_reg == OP_ADD || req_refresh_reg) begin
                        slot_age_reg[hit_idx_reg] <= use_count_reg;
                    end
                end else if (req_op_reg == OP_ADD) begin
                    slot_key_reg[victim_idx_reg] <= req_key_reg;
                    slot_age_reg[victim_idx_reg] <= use_count_reg;
                end
            end
        end
    end

    // request, search pipeline and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_op_reg      <= s_operation;
            req_key_reg     <= s_key;
            req_data_reg    <= s_entry_in[DATA_BITS-1:0];
            req_refresh_reg <= s_refresh;
        end
        if (cmd.look) begin
            match_reg <= match_next;
            for (int g = 0; g < NGRP; g++) begin
                grp_age_reg[g] <= grp_age_next[g];
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
        if (cmd.sel) begin
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            victim_idx_reg <= victim_idx_next;
        end
        if (cmd.load_out) begin
            m_hit_reg       <= hit_reg;
            m_entry_out_reg <= hit_reg ? ENTRY_W'(rd_data_reg) : '0;
        end
    end

    // data memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            rd_data_reg <= slot_data_mem[hit_idx_reg];
            if (!hit_reg && req_op_reg == OP_ADD) begin
                slot_data_mem[victim_idx_reg] <= req_data_reg;
            end
        end
    end

    assign m_hit       = m_hit_reg;
    assign m_entry_out = m_entry_out_reg;

endmodule

// ----- src/lru_assoc_cache.sv -----
// ----------------------------------------------------------------------------
// lru_assoc_cache
// fully associative keyed cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request: s_operation (find or add), s_key,
//   s_entry_in (data kept by an add whose key is absent) and s_refresh
//   (a find restamps the matching entry). every request gives one result
//   on the m_ channel: m_hit and m_entry_out (data on hit, zero on miss).
//   an add advances the use counter; on a miss it fills an empty slot or
//   replaces the slot with the oldest stamp.
//   a request passes the look, select and update steps in turn and is then
//   loaded into the result register; the key compare, the two-level
//   oldest-slot search and the single-port update of the slot arrays run
//   one after the other for each request.
//   a new request is taken in the cycle its predecessor's result is loaded,
//   so one finished result can wait in the output register while the next
//   request is at work; a stalled receiver holds the block before loading.
//   reset (synchronous, active low aresetn) empties every slot and clears
//   the use counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_assoc_cache
    import lac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [ENTRY_W-1:0]  s_entry_in,
    input  logic                s_refresh,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [ENTRY_W-1:0]  m_entry_out
);

    lac_cmd_t cmd;

    lac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lac_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_entry_in  (s_entry_in),
        .s_refresh   (s_refresh),
        .m_hit       (m_hit),
        .m_entry_out (m_entry_out)
    );

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one still in search");

    // a miss never returns data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_entry_out == '0))
        else $error("miss result carries nonzero data");

    // sequencer steps are exclusive
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.look, cmd.sel, cmd.upd, cmd.load_out}))
        else $error("more than one sequencer step active");

    // result register only loads when it is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten while stalled");

endmodule

// ----- bench/tb_lru_assoc_cache.sv -----
// ----------------------------------------------------------------------------
// tb_lru_assoc_cache
// self-checking bench for the lru associative cache: a short table of
// directed requests (empty cache, extreme keys and data, duplicate adds,
// filling every slot, eviction of the oldest stamp after a refresh) and then
// random find/add traffic over key pools of changing size. each result is
// compared with its typed table value or with a behavioral cache copy in the
// bench, with bursty requests and a receiver stalling in changing patterns.
// ----------------------------------------------------------------------------
module tb_lru_assoc_cache
    import lac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1700;
    localparam int KEY_POOL    = 40;
    localparam int MAX_SHOWN   = 10;

    localparam logic [ENTRY_W-1:0] DATA_MASK = {ENTRY_W{1'b1}} >> (ENTRY_W - DATA_BITS);

    typedef struct {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [ENTRY_W-1:0] data;
        logic               refresh;
        bit                 fixed;     // expected result typed into the table
        logic               exp_hit;
        logic [ENTRY_W-1:0] exp_data;
    } cache_req_t;

    typedef struct {
        logic               hit;
        logic [ENTRY_W-1:0] data;
    } lookup_res_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic               s_operation = OP_FIND;
    logic [KEY_W-1:0]   s_key       = '0;
    logic [ENTRY_W-1:0] s_entry_in  = '0;
    logic               s_refresh   = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_hit;
    logic [ENTRY_W-1:0] m_entry_out;

    lru_assoc_cache u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_entry_in  (s_entry_in),
        .s_refresh   (s_refresh),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_entry_out (m_entry_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // bench copy of the cache contents
    logic [KEY_W-1:0]   cached_key   [SLOTS];
    logic [ENTRY_W-1:0] cached_data  [SLOTS];
    logic [AGE_W-1:0]   cached_stamp [SLOTS];
    logic [AGE_W-1:0]   add_count;

    lookup_res_t pending_results[$];
    cache_req_t  dir_table[$];
    logic [KEY_W-1:0] key_pool[KEY_POOL];
    int mismatches = 0;
    int burst_left = 0;

    function automatic lookup_res_t cache_access(input cache_req_t r);
        lookup_res_t res;
        int match;
        int victim;
        bit empty_found;
        match = SLOTS;
        victim = 0;
        empty_found = 1'b0;
        if (r.op == OP_ADD)
            add_count = add_count + 1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (cached_stamp[i] != '0 && cached_key[i] == r.key)
                match = i;
        end
        if (match < SLOTS) begin
            res.hit = 1'b1;
            res.data = cached_data[match];
            if (r.op == OP_ADD || r.refresh)
                cached_stamp[match] = add_count;
        end else begin
            res.hit = 1'b0;
            res.data = '0;
            if (r.op == OP_ADD) begin
                // first empty slot, else lowest index of the oldest stamp
                for (int i = 0; i < SLOTS; i++) begin
                    if (!empty_found) begin
                        if (cached_stamp[i] == '0) begin
                            victim = i;
                            empty_found = 1'b1;
                        end else if (cached_stamp[i] < cached_stamp[victim]) begin
                            victim = i;
                        end
                    end
                end
                cached_key[victim] = r.key;
                cached_data[victim] = r.data & DATA_MASK;
                cached_stamp[victim] = add_count;
            end
        end
        return res;
    endfunction

    task automatic dir_row(input logic op, input logic [KEY_W-1:0] key,
                           input logic [ENTRY_W-1:0] data, input logic refresh,
                           input bit fixed, input logic exp_hit,
                           input logic [ENTRY_W-1:0] exp_data);
        cache_req_t r;
        r.op = op;
        r.key = key;
        r.data = data;
        r.refresh = refresh;
        r.fixed = fixed;
        r.exp_hit = exp_hit;
        r.exp_data = exp_data;
        dir_table.push_back(r);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input cache_req_t r);
        lookup_res_t res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_operation <= r.op;
        s_key       <= r.key;
        s_entry_in  <= r.data;
        s_refresh   <= r.refresh;
        do @(posedge aclk); while (!s_ready);
        res = cache_access(r);
        if (r.fixed) begin
            res.hit = r.exp_hit;
            res.data = r.exp_data;
        end
        pending_results.push_back(res);
        @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int pool_size);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // receiver: stall pattern switches to a random mode whenever its countdown expires
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(10, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge aclk) begin
        lookup_res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: hit=%0b data=%h", m_hit, m_entry_out);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_hit !== exp_res.hit || m_entry_out !== exp_res.data) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: expected hit=%0b data=%h, got hit=%0b data=%h",
                                 exp_res.hit, exp_res.data, m_hit, m_entry_out);
                end
            end
        end
    end

    initial begin
        cache_req_t r;
        int pool_size;
        for (int i = 0; i < SLOTS; i++) begin
            cached_key[i] = '0;
            cached_data[i] = '0;
            cached_stamp[i] = '0;
        end
        add_count = '0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        // empty cache: nothing matches, key zero included
        dir_row(OP_FIND, 32'h0000_0000, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0);
        dir_row(OP_FIND, 32'hFFFF_FFFF, '1,    1'b1, 1'b1, 1'b0, 64'h0);
        dir_row(OP_ADD,  32'h0000_0000, '1,    1'b0, 1'b1, 1'b0, 64'h0);
        dir_row(OP_FIND, 32'h0000_0000, 64'h0, 1'b0, 1'b1, 1'b1, '1);
        // duplicate add keeps the stored data and only restamps
        dir_row(OP_ADD,  32'h0000_0000, 64'h0, 1'b1, 1'b1, 1'b1, '1);
        dir_row(OP_ADD,  32'hFFFF_FFFF, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0);
        dir_row(OP_FIND, 32'hFFFF_FFFF, '1,    1'b0, 1'b1, 1'b1, 64'h0);
        // fill the remaining slots
        for (int i = 0; i < SLOTS - 2; i++)
            dir_row(OP_ADD, 32'h5A00_0000 + i, {$urandom, $urandom}, 1'b0, 1'b0, 1'b0, 64'h0);
        // refresh key zero, then the next add evicts the oldest (key all ones)
        dir_row(OP_FIND, 32'h0000_0000, 64'h0, 1'b1, 1'b0, 1'b0, 64'h0);
        dir_row(OP_ADD,  32'h0000_0100, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0, 1'b0, 64'h0);
        dir_row(OP_FIND, 32'hFFFF_FFFF, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_table[i])
            issue(dir_table[i]);

        pool_size = 8;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            // small pools give many hits, large ones force evictions
            if (n % 150 == 0)
                pool_size = $urandom_range(6, KEY_POOL);
            r.op = ($urandom_range(0, 1) == 0) ? OP_FIND : OP_ADD;
            r.key = pick_key(pool_size);
            r.data = {$urandom, $urandom};
            r.refresh = 1'($urandom_range(0, 1));
            r.fixed = 1'b0;
            r.exp_hit = 1'b0;
            r.exp_data = '0;
            issue(r);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/lac_pkg.sv
src/lac_ctrl.sv
src/lac_dpath.sv
src/lru_assoc_cache.sv
bench/tb_lru_assoc_cache.sv
